// ===== rtl/box_blur_3x3_edge_clipped_macros.svh =====
// Assertion macros for the 3x3 box blur block.
// Used by the top level; expects signals named clk and rst_n in the including scope.
`ifndef BOX_BLUR_3X3_EDGE_CLIPPED_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_CLIPPED_MACROS_SVH
`ifndef SYNTHESIS
// Check that holds in the same cycle as its trigger.
`define BB3_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("box blur same-cycle check failed");
// Check that holds in the cycle after its trigger.
`define BB3_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("box blur next-cycle check failed");
`else
`define BB3_ASSERT_SAME(label, ante, cons)
`define BB3_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/bb3_pkg.sv =====
// Shared types, sizes and constants for the 3x3 box blur block.
// No dependencies; imported by every module of the block.
`default_nettype none

package bb3_pkg;

    // Frame limits and derived counter widths.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // Configuration port.
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(480);

    // Pixel and window geometry.
    localparam int CH_W     = 8;
    localparam int LANES    = 3;
    localparam int PIX_W    = CH_W * LANES;
    localparam int WIN_TAPS = 9;

    // Lane arithmetic: sum of up to nine taps, then (2*sum + n) / (2*n).
    localparam int SUM_W       = 12;
    localparam int T_W         = SUM_W + 1;
    localparam int COUNT_W     = 4;
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_W     = 18;
    localparam int PROD_W      = T_W + RECIP_W;

    // Reciprocals of 2*n, rounded up, scaled by 2^RECIP_SHIFT.
    localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'((2**RECIP_SHIFT + 1) / 2);
    localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'((2**RECIP_SHIFT + 3) / 4);
    localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'((2**RECIP_SHIFT + 5) / 6);
    localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'((2**RECIP_SHIFT + 7) / 8);
    localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'((2**RECIP_SHIFT + 11) / 12);
    localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'((2**RECIP_SHIFT + 17) / 18);

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [WIN_TAPS-1:0][CH_W-1:0] taps_t;

    // One window column as it leaves the line store.
    typedef struct packed {
        pix_t cur;
        pix_t up1;
        pix_t up2;
    } column_t;

    // Position flags of the output pixel that an item produces.
    typedef struct packed {
        logic has_out;
        logic at_top;
        logic at_bottom;
        logic at_left;
        logic at_right;
        logic last;
    } pos_t;

    // Control from the window stage into every lane.
    typedef struct packed {
        logic                 load;
        logic [WIN_TAPS-1:0]  keep;
        logic [COUNT_W-1:0]   count;
    } lane_ctl_t;

    // Scaled reciprocal for a neighbour count.
    function automatic logic [RECIP_W-1:0] bb3_recip(input logic [COUNT_W-1:0] count);
        logic [RECIP_W-1:0] r;
        case (count)
            COUNT_W'(1): r = RECIP_1;
            COUNT_W'(2): r = RECIP_2;
            COUNT_W'(3): r = RECIP_3;
            COUNT_W'(4): r = RECIP_4;
            COUNT_W'(6): r = RECIP_6;
            COUNT_W'(9): r = RECIP_9;
            default:     r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bb3_line_store.sv =====
// Two line stores holding the previous two rows of pixels, one column per beat.
// Depends on bb3_pkg for sizes and the column type.
`default_nettype none

module bb3_line_store (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [bb3_pkg::COL_W-1:0] addr,
    input  bb3_pkg::pix_t         pix,
    output bb3_pkg::column_t      col
);
    import bb3_pkg::*;

    pix_t line1_mem [MAX_WIDTH];
    pix_t line2_mem [MAX_WIDTH];

    logic             pend_reg;
    logic [COL_W-1:0] pend_addr_reg;
    column_t          col_reg;
    logic             hit;

    // A read of the column still waiting to be written takes the pending data.
    assign hit = pend_reg && (pend_addr_reg == addr);
    assign col = col_reg;

    // The write of a beat lands in the cycle after its read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= rd_en;
        end
    end

    // Memory write of the pending column and registered read of the new one.
    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            line1_mem[pend_addr_reg] <= col_reg.cur;
            line2_mem[pend_addr_reg] <= col_reg.up1;
        end
        if (rd_en)
        begin
            pend_addr_reg <= addr;
            col_reg.cur   <= pix;
            if (hit)
            begin
                col_reg.up1 <= col_reg.cur;
                col_reg.up2 <= col_reg.up1;
            end
            else
            begin
                col_reg.up1 <= line1_mem[addr];
                col_reg.up2 <= line2_mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bb3_lane.sv =====
// One color lane: masked sum of the nine window taps and the rounded mean.
// Depends on bb3_pkg for widths, the tap type and the lane control struct.
`default_nettype none

module bb3_lane (
    input  logic                        clk,
    input  bb3_pkg::lane_ctl_t          ctl,
    input  bb3_pkg::taps_t              taps,
    input  logic [bb3_pkg::RECIP_W-1:0] recip,
    output logic [bb3_pkg::CH_W-1:0]    mean
);
    import bb3_pkg::*;

    logic [SUM_W-1:0]  sum;
    logic [T_W-1:0]    t_next;
    logic [T_W-1:0]    t_reg;
    logic [PROD_W-1:0] prod;

    // Sum of the taps that lie inside the frame, plus the rounding term.
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < WIN_TAPS; i++)
        begin
            if (ctl.keep[i])
            begin
                sum = sum + SUM_W'(taps[i]);
            end
        end
        t_next = {sum, 1'b0} + T_W'(ctl.count);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            t_reg <= t_next;
        end
    end

    // Division by 2*n as a multiply by its scaled reciprocal.
    assign prod = PROD_W'(t_reg) * PROD_W'(recip);
    assign mean = prod[RECIP_SHIFT +: CH_W];

endmodule

`default_nettype wire

// ===== rtl/bb3_merge.sv =====
// Output stage that joins the three lane means and the frame end flag into one beat.
// Depends on bb3_pkg for the channel width and lane count.
`default_nettype none

module bb3_merge (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    load,
    input  logic [bb3_pkg::LANES-1:0][bb3_pkg::CH_W-1:0] means,
    input  logic                                    last,
    input  logic                                    out_ready,
    output logic                                    ready,
    output logic                                    out_valid,
    output logic [bb3_pkg::CH_W-1:0]                red_out,
    output logic [bb3_pkg::CH_W-1:0]                green_out,
    output logic [bb3_pkg::CH_W-1:0]                blue_out,
    output logic                                    frame_end
);
    import bb3_pkg::*;

    logic            valid_reg;
    logic [CH_W-1:0] red_reg;
    logic [CH_W-1:0] green_reg;
    logic [CH_W-1:0] blue_reg;
    logic            end_reg;

    // The register takes a new beat when empty or when its beat leaves.
    assign ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Lane 0 is red, lane 1 green, lane 2 blue.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_reg   <= means[0];
            green_reg <= means[1];
            blue_reg  <= means[2];
            end_reg   <= last;
        end
    end

    assign out_valid = valid_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;
    assign frame_end = end_reg;

endmodule

`default_nettype wire

// ===== rtl/box_blur_3x3_edge_clipped.sv =====
// 3x3 box blur with edge clipping, top level.
// Depends on bb3_pkg, bb3_line_store, bb3_lane, bb3_merge and the assertion macros.
//
// Pixels enter in raster order on the pixel channel (valid/ready), one beat per
// pixel. Each result beat on the result channel is the half-up rounded mean of
// each color over the 3x3 neighbours inside the frame; frame_end marks the last
// pixel of a frame. Result k is caused by input beat k + width + 1, so after the
// last real pixel the source sends width + 1 flush beats.
// Registers on the path, in order: line store column, window, lane sum, output.
// Throughput: one beat per cycle unless stalled, set by the line store, which
// reads and writes a column each cycle; the three color lanes work side by side.
// The pipeline keeps accepting beats while a finished result waits, until its
// stages are full; a stalled receiver then holds pixel_ready low.
// Reset: the size registers return to 640 by 480 and all positions to zero.
// The line stores are not cleared; entries are always written before use.
// Configuration writes restart the frame; the user must make them while idle (not enforced).
`default_nettype none
`include "box_blur_3x3_edge_clipped_macros.svh"

module box_blur_3x3_edge_clipped (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pixel_valid,
    output logic                            pixel_ready,
    input  logic [bb3_pkg::CH_W-1:0]        red_in,
    input  logic [bb3_pkg::CH_W-1:0]        green_in,
    input  logic [bb3_pkg::CH_W-1:0]        blue_in,
    input  logic                            flush,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [bb3_pkg::CH_W-1:0]        red_out,
    output logic [bb3_pkg::CH_W-1:0]        green_out,
    output logic [bb3_pkg::CH_W-1:0]        blue_out,
    output logic                            frame_end,
    input  logic                            cfg_write,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bb3_pkg::CFG_W-1:0]       cfg_data
);
    import bb3_pkg::*;

    // Configuration and stream position.
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [COL_W-1:0] wm1;
    logic [ROW_W-1:0] hm1;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [1:0]       in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic             cfg_hit;
    pos_t             pos_now;
    pix_t             pix_in;

    // Pipeline control.
    logic accept;
    logic ld_out, ld1, ld2, ld3;
    logic move1, move2, move3;
    logic v1_reg, v2_reg, v3_reg;

    // Stage data.
    pos_t                s1_pos_reg;
    pos_t                s2_pos_reg;
    column_t             s1_col;
    pix_t                window_reg [WIN_TAPS];
    logic                s3_last_reg;
    logic [RECIP_W-1:0]  s3_recip_reg;
    logic [1:0]          row_n;
    logic [1:0]          col_n;
    lane_ctl_t           lane_ctl;
    taps_t               lane_taps [LANES];
    logic [LANES-1:0][CH_W-1:0] lane_means;

    // Effective frame size minus one: zero counts as one, large values saturate.
    always_comb
    begin
        if (width_reg == '0)
        begin
            wm1 = '0;
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            wm1 = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            wm1 = COL_W'(width_reg - CFG_W'(1));
        end

        if (height_reg == '0)
        begin
            hm1 = '0;
        end
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
        begin
            hm1 = ROW_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            hm1 = ROW_W'(height_reg - CFG_W'(1));
        end
    end

    // Handshake chain through the stages.
    assign ld3         = !v3_reg || ld_out;
    assign ld2         = !v2_reg || ld3;
    assign ld1         = !v1_reg || ld2;
    assign move3       = v3_reg && ld_out;
    assign move2       = v2_reg && ld3;
    assign move1       = v1_reg && ld2;
    assign pixel_ready = ld1;
    assign accept      = pixel_valid && ld1;

    assign cfg_hit = cfg_write &&
                     ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));
    assign pix_in  = flush ? '0 : {red_in, green_in, blue_in};

    // Position of the beat being accepted and the counters that follow it.
    always_comb
    begin
        pos_now.has_out   = !((in_row_reg == 2'd0) ||
                              ((in_row_reg == 2'd1) && (in_col_reg == '0)));
        pos_now.at_top    = (out_row_reg == '0);
        pos_now.at_bottom = (out_row_reg == hm1);
        pos_now.at_left   = (out_col_reg == '0);
        pos_now.at_right  = (out_col_reg == wm1);
        pos_now.last      = pos_now.at_bottom && pos_now.at_right;

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        if (cfg_hit || (accept && pos_now.has_out && pos_now.last))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (accept)
        begin
            if (in_col_reg == wm1)
            begin
                in_col_next = '0;
                if (in_row_reg != 2'd2)
                begin
                    in_row_next = in_row_reg + 2'd1;
                end
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end

            if (pos_now.has_out)
            begin
                if (pos_now.at_right)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    // Configuration registers, counters and stage valids.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= FRAME_WIDTH_RESET;
            height_reg  <= FRAME_HEIGHT_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write && (cfg_index == REG_FRAME_WIDTH))
            begin
                width_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == REG_FRAME_HEIGHT))
            begin
                height_reg <= cfg_data;
            end
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;

            if (accept)
            begin
                v1_reg <= 1'b1;
            end
            else if (move1)
            begin
                v1_reg <= 1'b0;
            end

            // Beats that cause no result still shift the window, then vanish.
            if (move1)
            begin
                v2_reg <= s1_pos_reg.has_out;
            end
            else if (move2)
            begin
                v2_reg <= 1'b0;
            end

            if (move2)
            begin
                v3_reg <= 1'b1;
            end
            else if (move3)
            begin
                v3_reg <= 1'b0;
            end
        end
    end

    // Column fetch from the line stores.
    bb3_line_store u_line_store (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (accept),
        .addr  (in_col_reg),
        .pix   (pix_in),
        .col   (s1_col)
    );

    // Stage data: position flags, window shift, shared reciprocal.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg <= pos_now;
        end
        if (move1)
        begin
            s2_pos_reg <= s1_pos_reg;
            for (int r = 0; r < 3; r++)
            begin
                window_reg[r*3]     <= window_reg[r*3 + 1];
                window_reg[r*3 + 1] <= window_reg[r*3 + 2];
            end
            window_reg[2] <= s1_col.up2;
            window_reg[5] <= s1_col.up1;
            window_reg[8] <= s1_col.cur;
        end
        if (move2)
        begin
            s3_last_reg  <= s2_pos_reg.last;
            s3_recip_reg <= bb3_recip(lane_ctl.count);
        end
    end

    // Which taps lie inside the frame, and how many.
    always_comb
    begin
        row_n = 2'd3 - {1'b0, s2_pos_reg.at_top} - {1'b0, s2_pos_reg.at_bottom};
        col_n = 2'd3 - {1'b0, s2_pos_reg.at_left} - {1'b0, s2_pos_reg.at_right};
        lane_ctl.load  = move2;
        lane_ctl.count = {2'b00, row_n} * {2'b00, col_n};
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                lane_ctl.keep[r*3 + c] = !(((r == 0) && s2_pos_reg.at_top) ||
                                           ((r == 2) && s2_pos_reg.at_bottom) ||
                                           ((c == 0) && s2_pos_reg.at_left) ||
                                           ((c == 2) && s2_pos_reg.at_right));
            end
        end
    end

    // Split the window into one byte per tap for each color lane.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            for (int i = 0; i < WIN_TAPS; i++)
            begin
                lane_taps[l][i] = window_reg[i][(LANES - 1 - l)*CH_W +: CH_W];
            end
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        bb3_lane u_lane (
            .clk   (clk),
            .ctl   (lane_ctl),
            .taps  (lane_taps[l]),
            .recip (s3_recip_reg),
            .mean  (lane_means[l])
        );
    end

    bb3_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (move3),
        .means     (lane_means),
        .last      (s3_last_reg),
        .out_ready (result_ready),
        .ready     (ld_out),
        .out_valid (result_valid),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .frame_end (frame_end)
    );

    // A size write puts the stream back at the start of a frame.
    `BB3_ASSERT_NEXT(a_cfg_restart, cfg_hit, (in_col_reg == '0) && (in_row_reg == 2'd0) && (out_col_reg == '0) && (out_row_reg == '0))
    // The last pixel of a frame restarts every position counter.
    `BB3_ASSERT_NEXT(a_frame_restart, accept && pos_now.has_out && pos_now.last, (in_col_reg == '0) && (out_col_reg == '0) && (out_row_reg == '0))
    // A window that produces a result always has a legal neighbour count.
    `BB3_ASSERT_SAME(a_count_legal, v2_reg, (lane_ctl.count == 4'd1) || (lane_ctl.count == 4'd2) || (lane_ctl.count == 4'd3) || (lane_ctl.count == 4'd4) || (lane_ctl.count == 4'd6) || (lane_ctl.count == 4'd9))

endmodule

`default_nettype wire

// ===== bench/tb_box_blur_3x3_edge_clipped.sv =====
// Self-checking bench for the 3x3 edge-clipped box blur: drives raster frames with drain beats
// and checks every blurred result against a predictor kept in a small scoreboard class.
// Depends on bb3_pkg and box_blur_3x3_edge_clipped from the rtl folder.
`timescale 1ns / 1ps

module tb_box_blur_3x3_edge_clipped;

    localparam int HISTORY_DEPTH = 2 * bb3_pkg::MAX_WIDTH + 3;
    localparam int CYCLE_LIMIT   = 8_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_BEATS  = 1620;
    localparam int SQUEEZE_AFTER = 600;
    localparam int SQUEEZE_LEN   = 400;
    localparam int PRINT_CAP     = 50;

    // One blurred output pixel.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } blur_px_t;

    typedef enum int {STYLE_PLAIN, STYLE_EXTREME, STYLE_NOISY} frame_style_e;

    // Tracks the stream position, the recent pixel history and the blurred pixels still owed.
    class blur_scoreboard;
        logic [11:0] width_reg;
        logic [11:0] height_reg;
        logic [23:0] history [HISTORY_DEPTH];
        int          in_col;
        int          in_row;
        int          out_col;
        int          out_row;
        blur_px_t    owed_blur [$];
        int          errors;
        int          results_seen;

        function new();
            width_reg  = bb3_pkg::FRAME_WIDTH_RESET;
            height_reg = bb3_pkg::FRAME_HEIGHT_RESET;
            foreach (history[i]) history[i] = '0;
            restart();
            errors       = 0;
            results_seen = 0;
        endfunction

        function void restart();
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        function int clip(int v, int top);
            if (v == 0) return 1;
            if (v > top) return top;
            return v;
        endfunction

        function int eff_width();
            return clip(width_reg, bb3_pkg::MAX_WIDTH);
        endfunction

        function int eff_height();
            return clip(height_reg, bb3_pkg::MAX_HEIGHT);
        endfunction

        function bit busy();
            return owed_blur.size() != 0;
        endfunction

        // A size write restarts the stream but keeps the history.
        function void set_reg(logic [1:0] idx, logic [11:0] val);
            case (idx)
                bb3_pkg::REG_FRAME_WIDTH:  width_reg = val;
                bb3_pkg::REG_FRAME_HEIGHT: height_reg = val;
                default: ;
            endcase
            restart();
        endfunction

        function void step_in(int w);
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        endfunction

        function logic [7:0] round_mean(int sum, int n);
            return 8'((2 * sum + n) / (2 * n));
        endfunction

        // Store the accepted beat and, once the window is primed, predict one blurred pixel.
        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fl);
            int          w;
            int          h;
            int          lin;
            int          rr;
            int          cc;
            int          count;
            int          sum_r;
            int          sum_g;
            int          sum_b;
            logic [23:0] px;
            blur_px_t    res;

            w   = eff_width();
            h   = eff_height();
            lin = in_row * w + in_col;
            px  = fl ? 24'h0 : {r, g, b};
            history[lin % HISTORY_DEPTH] = px;
            if (lin < w + 1) begin
                step_in(w);
                return;
            end

            // Sum the neighbors that lie inside the frame.
            count = 0;
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    rr = out_row + dr;
                    cc = out_col + dc;
                    if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
                        px = history[(rr * w + cc) % HISTORY_DEPTH];
                        sum_r += px[23:16];
                        sum_g += px[15:8];
                        sum_b += px[7:0];
                        count++;
                    end
                end
            end
            res.red   = round_mean(sum_r, count);
            res.green = round_mean(sum_g, count);
            res.blue  = round_mean(sum_b, count);
            res.last  = (out_row + 1 >= h) && (out_col + 1 >= w);
            owed_blur.push_back(res);

            if (res.last) begin
                restart();
                return;
            end
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
            step_in(w);
        endfunction

        // Printing stops after a while so a broken block cannot flood the log; counting goes on.
        task report(string what);
            errors++;
            if (errors <= PRINT_CAP) $display("MISMATCH: %s", what);
        endtask

        task check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fe);
            blur_px_t want;
            results_seen++;
            if (owed_blur.size() == 0) begin
                report($sformatf("result %0d arrived with nothing owed (%0d %0d %0d end=%0b)",
                                 results_seen, r, g, b, fe));
                return;
            end
            want = owed_blur.pop_front();
            if (r !== want.red)
                report($sformatf("result %0d red %0d, want %0d", results_seen, r, want.red));
            if (g !== want.green)
                report($sformatf("result %0d green %0d, want %0d", results_seen, g, want.green));
            if (b !== want.blue)
                report($sformatf("result %0d blue %0d, want %0d", results_seen, b, want.blue));
            if (fe !== want.last)
                report($sformatf("result %0d frame_end %0b, want %0b", results_seen, fe,
                                 want.last));
        endtask
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            pixel_valid = 1'b0;
    logic                            pixel_ready;
    logic [bb3_pkg::CH_W-1:0]        red_in = '0;
    logic [bb3_pkg::CH_W-1:0]        green_in = '0;
    logic [bb3_pkg::CH_W-1:0]        blue_in = '0;
    logic                            flush = 1'b0;
    logic                            result_valid;
    logic                            result_ready = 1'b0;
    logic [bb3_pkg::CH_W-1:0]        red_out;
    logic [bb3_pkg::CH_W-1:0]        green_out;
    logic [bb3_pkg::CH_W-1:0]        blue_out;
    logic                            frame_end;
    logic                            cfg_write = 1'b0;
    logic [bb3_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [bb3_pkg::CFG_W-1:0]       cfg_data = '0;

    blur_scoreboard board;
    int  cycles = 0;
    int  stalled_cycles = 0;
    int  beats_sent = 0;
    int  frames_sent = 0;
    int  settings_used = 0;
    bit  tx_steady = 1'b0;
    int  hold_left = 0;
    int  open_left = 0;
    int  squeeze_left = 0;
    bit  squeeze_done = 1'b0;

    box_blur_3x3_edge_clipped uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .flush        (flush),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .frame_end    (frame_end),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Idle length: mostly none, often short, now and then a long stretch.
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(3, 1);
        if (roll < 98) return $urandom_range(15, 4);
        return $urandom_range(60, 20);
    endfunction

    // Watchdog, plus a count of cycles where the block held off an offered beat.
    always @(posedge clk)
    begin
        cycles++;
        if (pixel_valid && !pixel_ready) stalled_cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results still owed.", cycles,
                     board.owed_blur.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: check each accepted beat, then pick the next ready level.
    // One long hold-off lets the pipeline fill so that pixel_ready drops.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
                board.check_result(red_out, green_out, blue_out, frame_end);
            if (!squeeze_done && board.results_seen >= SQUEEZE_AFTER)
            begin
                squeeze_done = 1'b1;
                squeeze_left = SQUEEZE_LEN;
            end
            if (squeeze_left > 0)
            begin
                squeeze_left--;
                result_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (open_left > 0)
            begin
                open_left--;
                result_ready <= 1'b1;
            end
            else if ($urandom_range(99) < 3)
            begin
                open_left = $urandom_range(200, 50);
                result_ready <= 1'b1;
            end
            else
            begin
                hold_left = idle_gap();
                result_ready <= (hold_left == 0);
                if (hold_left > 0) hold_left--;
            end
        end
    end

    // Offer one pixel beat and wait until it is taken.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic fl);
        int gap;
        gap = tx_steady ? 0 : idle_gap();
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        red_in      <= r;
        green_in    <= g;
        blue_in     <= b;
        flush       <= fl;
        @(posedge clk);
        while (!pixel_ready) @(posedge clk);
        board.note_pixel(r, g, b, fl);
        beats_sent++;
    endtask

    // Stop offering, let every owed result come back, then let the pipeline settle.
    task automatic settle();
        pixel_valid <= 1'b0;
        while (board.busy()) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        board.set_reg(idx, val);
    endtask

    task automatic set_size(input logic [11:0] wv, input logic [11:0] hv,
                            input bit write_w, input bit write_h);
        settle();
        if (write_w) write_reg(bb3_pkg::REG_FRAME_WIDTH, wv);
        if (write_h) write_reg(bb3_pkg::REG_FRAME_HEIGHT, hv);
        cfg_write <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // One whole frame followed by its width + 1 drain beats, in a random style.
    task automatic send_frame();
        int           w;
        int           h;
        int           roll;
        frame_style_e style;
        logic [7:0]   r;
        logic [7:0]   g;
        logic [7:0]   b;
        logic         fl;

        w    = board.eff_width();
        h    = board.eff_height();
        roll = $urandom_range(99);
        style = (roll < 60) ? STYLE_PLAIN : (roll < 80) ? STYLE_EXTREME : STYLE_NOISY;
        tx_steady = ($urandom_range(99) < 20);

        for (int i = 0; i < w * h; i++)
        begin
            r  = 8'($urandom_range(255));
            g  = 8'($urandom_range(255));
            b  = 8'($urandom_range(255));
            fl = 1'b0;
            if (style == STYLE_EXTREME)
            begin
                r = $urandom_range(1) ? 8'hFF : 8'h00;
                g = $urandom_range(1) ? 8'hFF : 8'h00;
                b = $urandom_range(1) ? 8'hFF : 8'h00;
            end
            else if (style == STYLE_NOISY)
                fl = ($urandom_range(99) < 10);
            send_pixel(r, g, b, fl);
        end

        // Drain beats; noisy frames sometimes put real pixels here.
        for (int i = 0; i <= w; i++)
        begin
            fl = !(style == STYLE_NOISY && $urandom_range(99) < 30);
            send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), fl);
        end
        frames_sent++;
    endtask

    task automatic run_setting(input logic [11:0] wv, input logic [11:0] hv,
                               input bit write_w, input bit write_h, input int frames);
        set_size(wv, hv, write_w, write_h);
        repeat (frames) send_frame();
    endtask

    initial
    begin
        int         start_beats;
        int         roll;
        logic [11:0] wv;
        logic [11:0] hv;

        board = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x3 frame: full, edge and corner windows, extreme colors, a flush among the
        // pixels, and a real pixel inside the drain.
        set_size(12'd3, 12'd3, 1'b1, 1'b1);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'h00, 8'h80, 1'b0);
        send_pixel(8'h01, 8'h02, 8'h03, 1'b0);
        send_pixel(8'hC8, 8'hC8, 8'hC8, 1'b1);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
        send_pixel(8'h80, 8'h7F, 8'h01, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFE, 1'b0);
        send_pixel(8'h12, 8'h34, 8'h56, 1'b1);
        send_pixel(8'hAB, 8'hCD, 8'hEF, 1'b1);
        send_pixel(8'h4D, 8'h58, 8'h63, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);

        // Single-pixel frame: the mean over one neighbor.
        set_size(12'd1, 12'd1, 1'b1, 1'b1);
        send_pixel(8'hFF, 8'h80, 8'h01, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);

        // 2x2 frame: four neighbors everywhere, rounding at both ends of the range.
        set_size(12'd2, 12'd2, 1'b1, 1'b1);
        send_pixel(8'hFF, 8'h01, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'h01, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hFE, 8'h01, 8'h01, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);

        // Zero sizes, which count as one, alone and paired with a small other dimension.
        run_setting(12'd0, 12'd0, 1'b1, 1'b1, 1);
        run_setting(12'd0, 12'd5, 1'b1, 1'b1, 2);
        run_setting(12'd7, 12'd0, 1'b1, 1'b1, 2);

        // Random sizes, mostly small, sometimes only one register rewritten.
        start_beats = beats_sent;
        while (beats_sent - start_beats < RANDOM_BEATS)
        begin
            roll = $urandom_range(99);
            wv = (roll < 70) ? 12'($urandom_range(8)) : 12'($urandom_range(40, 9));
            hv = ($urandom_range(99) < 80) ? 12'($urandom_range(8)) : 12'($urandom_range(20, 9));
            roll = $urandom_range(99);
            run_setting(wv, hv, roll < 85, roll >= 70, $urandom_range(3, 1));
        end

        settle();
        if (board.busy())
            board.report($sformatf("%0d results never arrived", board.owed_blur.size()));

        $display("Sent %0d pixel beats in %0d frames over %0d size settings; checked %0d results.",
                 beats_sent, frames_sent, settings_used, board.results_seen);
        $display("The pixel input was held off on %0d cycles; %0d mismatches counted.",
                 stalled_cycles, board.errors);
        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
